[hw/rtl/mkd_pkg.sv]
// Morse key decoder package: configuration record, register indexes and
// character codes shared by the decoder top level and its character ROM.
// No dependencies.
package mkd_pkg;

  localparam int CODE_W = 7;
  localparam int PAT_W = 7;
  localparam int ROM_COUNT_W = 4;
  localparam int TICK_W = 16;
  localparam int LIMIT_W = 15;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [CODE_W-1:0] code_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DECODE_ENABLE = 3'd0,
    REG_AUTO_SPACE    = 3'd1,
    REG_DOT_LIMIT     = 3'd2,
    REG_LONG_LIMIT    = 3'd3,
    REG_CHAR_GAP      = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic               decode_enable;
    logic               auto_space;
    logic [LIMIT_W-1:0] dot_limit;
    logic [LIMIT_W-1:0] long_limit;
    logic [TICK_W-1:0]  char_gap;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    decode_enable: 1'b1,
    auto_space:    1'b1,
    dot_limit:     15'd200,
    long_limit:    15'd1000,
    char_gap:      16'd400
  };

  localparam code_t CODE_NONE    = 7'h00;
  localparam code_t CODE_NEWLINE = 7'h0A;
  localparam code_t CODE_SPACE   = 7'h20;

endpackage

[hw/rtl/mkd_char_rom.sv]
// Morse key decoder character ROM: maps an element pattern (first element
// most significant, 1 = dash) and its length to ASCII, or to no character.
// Depends on mkd_pkg.
module mkd_char_rom (
  input  logic [mkd_pkg::ROM_COUNT_W-1:0] count,
  input  logic [mkd_pkg::PAT_W-1:0]       pattern,
  output mkd_pkg::code_t                  code
);

  logic [mkd_pkg::PAT_W-1:0] mask;
  logic [mkd_pkg::PAT_W-1:0] masked;

  always_comb begin
    mask = ~({mkd_pkg::PAT_W{1'b1}} << count[2:0]);
    masked = pattern & mask;
  end

  always_comb begin
    code = mkd_pkg::CODE_NONE;
    if (count[3] == 1'b0) begin
      case ({count[2:0], masked})
        {3'd2, 7'(2'b01)}:      code = 7'h41;
        {3'd4, 7'(4'b1000)}:    code = 7'h42;
        {3'd4, 7'(4'b1010)}:    code = 7'h43;
        {3'd3, 7'(3'b100)}:     code = 7'h44;
        {3'd1, 7'(1'b0)}:       code = 7'h45;
        {3'd4, 7'(4'b0010)}:    code = 7'h46;
        {3'd3, 7'(3'b110)}:     code = 7'h47;
        {3'd4, 7'(4'b0000)}:    code = 7'h48;
        {3'd2, 7'(2'b00)}:      code = 7'h49;
        {3'd4, 7'(4'b0111)}:    code = 7'h4A;
        {3'd3, 7'(3'b101)}:     code = 7'h4B;
        {3'd4, 7'(4'b0100)}:    code = 7'h4C;
        {3'd2, 7'(2'b11)}:      code = 7'h4D;
        {3'd2, 7'(2'b10)}:      code = 7'h4E;
        {3'd3, 7'(3'b111)}:     code = 7'h4F;
        {3'd4, 7'(4'b0110)}:    code = 7'h50;
        {3'd4, 7'(4'b1101)}:    code = 7'h51;
        {3'd3, 7'(3'b010)}:     code = 7'h52;
        {3'd3, 7'(3'b000)}:     code = 7'h53;
        {3'd1, 7'(1'b1)}:       code = 7'h54;
        {3'd3, 7'(3'b001)}:     code = 7'h55;
        {3'd4, 7'(4'b0001)}:    code = 7'h56;
        {3'd3, 7'(3'b011)}:     code = 7'h57;
        {3'd4, 7'(4'b1001)}:    code = 7'h58;
        {3'd4, 7'(4'b1011)}:    code = 7'h59;
        {3'd4, 7'(4'b1100)}:    code = 7'h5A;
        {3'd5, 7'(5'b11111)}:   code = 7'h30;
        {3'd5, 7'(5'b01111)}:   code = 7'h31;
        {3'd5, 7'(5'b00111)}:   code = 7'h32;
        {3'd5, 7'(5'b00011)}:   code = 7'h33;
        {3'd5, 7'(5'b00001)}:   code = 7'h34;
        {3'd5, 7'(5'b00000)}:   code = 7'h35;
        {3'd5, 7'(5'b10000)}:   code = 7'h36;
        {3'd5, 7'(5'b11000)}:   code = 7'h37;
        {3'd5, 7'(5'b11100)}:   code = 7'h38;
        {3'd5, 7'(5'b11110)}:   code = 7'h39;
        {3'd6, 7'(6'b010101)}:  code = 7'h2E;
        {3'd6, 7'(6'b110011)}:  code = 7'h2C;
        {3'd6, 7'(6'b001100)}:  code = 7'h3F;
        {3'd6, 7'(6'b011110)}:  code = 7'h27;
        {3'd6, 7'(6'b101011)}:  code = 7'h21;
        {3'd5, 7'(5'b10010)}:   code = 7'h2F;
        {3'd5, 7'(5'b10110)}:   code = 7'h28;
        {3'd6, 7'(6'b101101)}:  code = 7'h29;
        {3'd5, 7'(5'b01000)}:   code = 7'h26;
        {3'd6, 7'(6'b111000)}:  code = 7'h3A;
        {3'd6, 7'(6'b101010)}:  code = 7'h3B;
        {3'd5, 7'(5'b10001)}:   code = 7'h3D;
        {3'd5, 7'(5'b01010)}:   code = 7'h2B;
        {3'd6, 7'(6'b100001)}:  code = 7'h2D;
        {3'd6, 7'(6'b001101)}:  code = 7'h5F;
        {3'd6, 7'(6'b010010)}:  code = 7'h22;
        {3'd7, 7'b0001001}:     code = 7'h24;
        {3'd6, 7'(6'b011010)}:  code = 7'h40;
        default:                code = mkd_pkg::CODE_NONE;
      endcase
    end
  end

endmodule

[hw/rtl/morse_key_decoder.sv]
// Morse key decoder top level: tick input register, timing and pattern
// state, result register and configuration registers.
// Depends on mkd_pkg and mkd_char_rom.

// One key sample (tick) enters per word on the input channel; a tick can be
// accepted every clock cycle unless the output stalls, and a character it
// produces is offered on the output channel. The only latency is the
// input register followed by the result register; a stalled output holds one
// character while the next tick waits in the input register. Press and
// release runs are timed in ticks, not clock cycles. Configuration writes are
// taken at any time and act on the next tick; no clearing pass follows reset.
module morse_key_decoder #(
  parameter int MAX_ELEMENTS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mkd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mkd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             key_down,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mkd_pkg::CODE_W-1:0]       char_code
);

  localparam int CountW = $clog2(MAX_ELEMENTS + 1);
  localparam int RomCountW = mkd_pkg::ROM_COUNT_W;
  localparam int TickW = mkd_pkg::TICK_W;
  localparam int WideW = MAX_ELEMENTS + mkd_pkg::PAT_W;

  mkd_pkg::cfg_t cfg;

  logic in_full;
  logic in_key;
  logic advance;

  logic                    prev_level;
  logic [TickW-1:0]        press_ticks;
  logic [TickW-1:0]        release_ticks;
  logic                    space_pending;
  logic [MAX_ELEMENTS-1:0] elements;
  logic [CountW-1:0]       element_count;

  logic                    prev_level_next;
  logic [TickW-1:0]        press_ticks_next;
  logic [TickW-1:0]        release_ticks_next;
  logic                    space_pending_next;
  logic [MAX_ELEMENTS-1:0] elements_next;
  logic [CountW-1:0]       element_count_next;
  logic                    emit;
  mkd_pkg::code_t          emit_code;

  logic [TickW-1:0]        press_inc;
  logic [TickW-1:0]        release_inc;
  logic [TickW:0]          long_x3;
  logic [CountW-1:0]       count_app;
  logic [WideW-1:0]        elem_wide;
  mkd_pkg::code_t          rom_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= mkd_pkg::CFG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        mkd_pkg::REG_DECODE_ENABLE: cfg.decode_enable <= cfg_data[0];
        mkd_pkg::REG_AUTO_SPACE:    cfg.auto_space <= cfg_data[0];
        mkd_pkg::REG_DOT_LIMIT:     cfg.dot_limit <= cfg_data[mkd_pkg::LIMIT_W-1:0];
        mkd_pkg::REG_LONG_LIMIT:    cfg.long_limit <= cfg_data[mkd_pkg::LIMIT_W-1:0];
        mkd_pkg::REG_CHAR_GAP:      cfg.char_gap <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_key <= key_down;
    end
  end

  assign elem_wide = WideW'(elements);

  mkd_char_rom u_rom (
    .count   (RomCountW'(element_count)),
    .pattern (elem_wide[mkd_pkg::PAT_W-1:0]),
    .code    (rom_code)
  );

  always_comb begin
    press_inc = (press_ticks == {TickW{1'b1}}) ? press_ticks : press_ticks + 1'b1;
    release_inc = (release_ticks == {TickW{1'b1}}) ? release_ticks : release_ticks + 1'b1;
    long_x3 = {1'b0, 1'b0, cfg.long_limit} + {1'b0, cfg.long_limit, 1'b0};
  end

  always_comb begin
    prev_level_next = prev_level;
    press_ticks_next = press_ticks;
    release_ticks_next = release_ticks;
    space_pending_next = space_pending;
    elements_next = elements;
    element_count_next = element_count;
    count_app = element_count;
    emit = 1'b0;
    emit_code = mkd_pkg::CODE_NONE;
    if (cfg.decode_enable) begin
      if (in_key) begin
        if (!prev_level) begin
          prev_level_next = 1'b1;
          press_ticks_next = '0;
          release_ticks_next = '0;
        end else begin
          press_ticks_next = press_inc;
          if (press_inc == {1'b0, cfg.long_limit}) begin
            element_count_next = '0;
            emit = 1'b1;
            emit_code = mkd_pkg::CODE_NEWLINE;
          end
        end
      end else if (prev_level) begin
        prev_level_next = 1'b0;
        release_ticks_next = '0;
        space_pending_next = 1'b1;
      end else begin
        release_ticks_next = release_inc;
        if (release_inc == TickW'(1)) begin
          if (press_ticks != '0) begin
            if (press_ticks < {1'b0, cfg.dot_limit}) begin
              elements_next = {elements[MAX_ELEMENTS-2:0], 1'b0};
              count_app = element_count + 1'b1;
            end else if (press_ticks < {1'b0, cfg.long_limit}) begin
              elements_next = {elements[MAX_ELEMENTS-2:0], 1'b1};
              count_app = element_count + 1'b1;
            end
          end
          element_count_next = (count_app >= CountW'(MAX_ELEMENTS)) ? '0 : count_app;
        end else if (release_inc == cfg.char_gap && element_count != '0) begin
          element_count_next = '0;
          if (rom_code != mkd_pkg::CODE_NONE) begin
            emit = 1'b1;
            emit_code = rom_code;
          end
        end else if ({1'b0, release_inc} == long_x3 && cfg.auto_space && space_pending) begin
          space_pending_next = 1'b0;
          emit = 1'b1;
          emit_code = mkd_pkg::CODE_SPACE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= 1'b0;
      press_ticks <= '0;
      release_ticks <= '0;
      space_pending <= 1'b0;
      element_count <= '0;
    end else if (advance) begin
      prev_level <= prev_level_next;
      press_ticks <= press_ticks_next;
      release_ticks <= release_ticks_next;
      space_pending <= space_pending_next;
      element_count <= element_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      elements <= elements_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      char_code <= emit_code;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    element_count < CountW'(MAX_ELEMENTS))
    else $error("element count reached buffer depth");

  assert property (@(posedge clk) disable iff (rst)
    advance && emit && emit_code == mkd_pkg::CODE_NEWLINE |=> element_count == '0)
    else $error("pattern not cleared after newline");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance))
    else $error("result appeared without a tick");
`endif

endmodule
